FILE: hw/rtl/vpk_pkg.sv
// Package for the varint packer: sizes, action codes and the internal beat type.
// No dependencies; imported by every other file in hw/rtl except vpk_ram.
package vpk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 31;
  localparam int BYTE_BITS = 8;
  localparam int LEN_W     = 2;
  localparam int RUN_W     = 6;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [RUN_W-1:0] RUN_CAP = '1;

  localparam logic ACT_PACK   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // one candidate result byte offered to the output register
  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } vpk_beat_t;

endpackage

FILE: hw/rtl/vpk_in_if.sv
// Input channel of the varint packer: valid/ready plus action and value.
// Depends on vpk_pkg.
interface vpk_in_if import vpk_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

FILE: hw/rtl/vpk_out_if.sv
// Result channel of the varint packer: valid/ready plus byte and flags.
// Depends on vpk_pkg.
interface vpk_out_if import vpk_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 is_trailer;
  logic                 overflow;
  logic                 last_of_run;

  modport source (output valid, out_byte, is_trailer, overflow, last_of_run, input ready);
  modport sink   (input valid, out_byte, is_trailer, overflow, last_of_run, output ready);
endinterface

FILE: hw/rtl/vpk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vpk_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/vpk_byte_ser.sv
// Byte serialiser: shifts a value out one byte per beat, low byte first,
// stopping once the remaining bits are zero. Depends on vpk_pkg.
module vpk_byte_ser import vpk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [VALUE_W-1:0] value,
  input  logic               room,
  output vpk_beat_t          beat,
  output logic [LEN_W-1:0]   lenm1
);

  logic               busy;
  logic [VALUE_W-1:0] shreg;
  logic [LEN_W-1:0]   nbyte;
  logic               top_zero;

  assign top_zero   = (shreg[VALUE_W-1:BYTE_BITS] == '0);
  assign beat.valid = busy;
  assign beat.data  = shreg[BYTE_BITS-1:0];
  assign beat.last  = top_zero;
  assign lenm1      = nbyte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && room && top_zero) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= value;
      nbyte <= '0;
    end else if (busy && room) begin
      shreg <= shreg >> BYTE_BITS;
      nbyte <= nbyte + LEN_W'(1);
    end
  end

endmodule

FILE: hw/rtl/vpk_run_walk.sv
// Run walker: reads stored lengths newest first, one per cycle when
// not stalled; a trailer beat per equal-length run. Uses vpk_pkg.
module vpk_run_walk import vpk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] count_m1,
  input  logic             room,
  input  logic [LEN_W-1:0] rdata,
  output logic             re,
  output logic [IDX_W-1:0] raddr,
  output vpk_beat_t        beat
);

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_FIRST = 4'b0010,
    W_NEXT  = 4'b0100,
    W_FINAL = 4'b1000
  } walk_state_t;

  walk_state_t      state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] prev, prev_next;
  logic [RUN_W-1:0] run, run_next;
  logic             same;
  logic             adv;

  assign same       = (rdata == prev) && (run != RUN_CAP);
  assign raddr      = (state == W_IDLE) ? count_m1 : idx - IDX_W'(1);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    prev_next  = prev;
    run_next   = run;
    re         = 1'b0;
    adv        = 1'b0;
    beat.valid = 1'b0;
    beat.data  = {prev, run};
    beat.last  = 1'b0;
    unique case (state)
      W_IDLE: begin
        if (start) begin
          re         = 1'b1;
          idx_next   = count_m1;
          state_next = W_FIRST;
        end
      end
      W_FIRST: begin
        prev_next = rdata;
        run_next  = RUN_W'(1);
        adv       = 1'b1;
      end
      W_NEXT: begin
        if (same) begin
          run_next = run + RUN_W'(1);
          adv      = 1'b1;
        end else begin
          // run closes: hold the read data until the beat gets out
          beat.valid = 1'b1;
          if (room) begin
            prev_next = rdata;
            run_next  = RUN_W'(1);
            adv       = 1'b1;
          end
        end
      end
      W_FINAL: begin
        beat.valid = 1'b1;
        beat.last  = 1'b1;
        if (room) begin
          state_next = W_IDLE;
        end
      end
      default: begin
        state_next = W_IDLE;
      end
    endcase

    if (adv) begin
      if (idx == '0) begin
        state_next = W_FINAL;
      end else begin
        re         = 1'b1;
        idx_next   = idx - IDX_W'(1);
        state_next = W_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    prev <= prev_next;
    run  <= run_next;
  end

endmodule

FILE: hw/rtl/varint_pack_with_rle_length_trailer.sv
// Top level of the varint packer with run-length size trailer.
// Depends on vpk_pkg, vpk_in_if, vpk_out_if, vpk_ram, vpk_byte_ser, vpk_run_walk.
//
//   port    dir   role    payload
//   item    in    sink    action, value
//   result  out   source  out_byte, is_trailer, overflow, last_of_run
//
// Pack: the item is accepted, then the byte shift register emits one data
// byte per beat (1..4 bytes). Overflow: a single overflow beat is emitted.
// Finish: the walker reads each stored length through the store's single read
// port. Finish with nothing stored emits nothing.
// Reset clears control, the length count and result valid; the length store
// is not cleared and has no clearing pass.
// A stalled result holds in the output register; items are taken while idle
// even with a result waiting, and work halts only when a beat cannot leave.
module varint_pack_with_rle_length_trailer import vpk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vpk_in_if.sink    item,
  vpk_out_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PACK = 4'b0010,
    S_OVF  = 4'b0100,
    S_FIN  = 4'b1000
  } top_state_t;

  top_state_t       state, state_next;
  logic [CNT_W-1:0] item_count;
  logic [CNT_W-1:0] count_dec;
  logic             room;
  logic             accept;
  logic             full;
  logic             ser_load;
  logic             walk_start;
  logic             ram_we;
  logic             fin_done;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [LEN_W-1:0] ram_rdata;
  logic [LEN_W-1:0] ser_lenm1;
  vpk_beat_t        ser_beat;
  vpk_beat_t        walk_beat;

  logic                 emit_valid;
  logic [BYTE_BITS-1:0] emit_data;
  logic                 emit_trailer;
  logic                 emit_ovf;
  logic                 emit_last;

  assign room        = !result.valid || result.ready;
  assign item.ready  = (state == S_IDLE);
  assign accept      = item.valid && item.ready;
  assign full        = (item_count == CNT_W'(MAX_ITEMS));
  assign ser_load    = accept && (item.action == ACT_PACK) && !full;
  assign walk_start  = accept && (item.action == ACT_FINISH) && (item_count != '0);
  assign count_dec   = item_count - CNT_W'(1);
  assign ram_we      = (state == S_PACK) && ser_beat.valid && ser_beat.last && room;
  assign fin_done    = (state == S_FIN) && walk_beat.valid && walk_beat.last && room;

  vpk_byte_ser u_ser (
    .clk   (clk),
    .rst   (rst),
    .load  (ser_load),
    .value (item.value),
    .room  (room),
    .beat  (ser_beat),
    .lenm1 (ser_lenm1)
  );

  vpk_run_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .count_m1 (count_dec[IDX_W-1:0]),
    .room     (room),
    .rdata    (ram_rdata),
    .re       (ram_re),
    .raddr    (ram_raddr),
    .beat     (walk_beat)
  );

  vpk_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_ITEMS)
  ) u_len_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_count[IDX_W-1:0]),
    .wdata (ser_lenm1),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    emit_valid   = 1'b0;
    emit_data    = '0;
    emit_trailer = 1'b0;
    emit_ovf     = 1'b0;
    emit_last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        emit_valid = 1'b0;
      end
      S_PACK: begin
        emit_valid = ser_beat.valid;
        emit_data  = ser_beat.data;
        emit_last  = ser_beat.last;
      end
      S_OVF: begin
        emit_valid = 1'b1;
        emit_ovf   = 1'b1;
        emit_last  = 1'b1;
      end
      S_FIN: begin
        emit_valid   = walk_beat.valid;
        emit_data    = walk_beat.data;
        emit_trailer = 1'b1;
        emit_last    = walk_beat.last;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.action == ACT_PACK) begin
            state_next = full ? S_OVF : S_PACK;
          end else if (item_count != '0) begin
            state_next = S_FIN;
          end
        end
      end
      S_PACK: begin
        if (ram_we) begin
          state_next = S_IDLE;
        end
      end
      S_OVF: begin
        if (room) begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (fin_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_count <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        item_count <= item_count + CNT_W'(1);
      end else if (fin_done) begin
        item_count <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (room) begin
      result.valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && emit_valid) begin
      result.out_byte    <= emit_data;
      result.is_trailer  <= emit_trailer;
      result.overflow    <= emit_ovf;
      result.last_of_run <= emit_last;
    end
  end

  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |->
      result.last_of_run && !result.is_trailer && (result.out_byte == '0))
    else $error("overflow beat malformed");

  a_full_rejects: assert property (@(posedge clk) disable iff (rst)
    accept && (item.action == ACT_PACK) && full |=>
      (state == S_OVF) && $stable(item_count))
    else $error("pack into full store not rejected");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (item_count < CNT_W'(MAX_ITEMS)) && !ram_re)
    else $error("length store written when full or during a walk");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(ser_beat.valid && walk_beat.valid))
    else $error("serialiser and walker both offering a beat");

endmodule
